[sv/icce_pkg.sv]
// shared types, constants and sequence rom for the inline colour code expander
// no dependencies; imported by icce_front, icce_queue, icce_back and the top level

package icce_pkg;

  // ascii bytes used in more than one place
  localparam logic [7:0] CH_ESC  = 8'h1b;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_BSL  = 8'h5c;
  localparam logic [7:0] CH_C    = 8'h63;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_US   = 8'h5f;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // kind of the middle part of a step
  localparam logic [1:0] MID_NONE = 2'd0;
  localparam logic [1:0] MID_LIT  = 2'd1;
  localparam logic [1:0] MID_ROM  = 2'd2;
  localparam logic [1:0] MID_BANG = 2'd3;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // one step's results: flushed literals, middle part, end flush, marker
  // b1, b2, b3 and total are the running result positions of each part
  typedef struct packed {
    logic       pre_amp;
    logic       post_amp;
    logic [3:0] digit;
    logic [1:0] mid_kind;
    logic [7:0] mid_byte;
    logic [4:0] rom_idx;
    logic [2:0] b1;
    logic [2:0] b2;
    logic [2:0] b3;
    logic [2:0] total;
    logic       marker_ov;
    logic       text_end;
  } desc_t;

  // sequence length in bytes
  function automatic logic [2:0] rom_len(input logic [4:0] idx);
    logic [2:0] n;
    if (idx == 5'd0) n = 3'd6;
    else if (idx <= 5'd14) n = 3'd7;
    else if (idx <= 5'd21) n = 3'd5;
    else if (idx == 5'd22 || idx == 5'd23) n = 3'd1;
    else if (idx == 5'd24) n = 3'd5;
    else if (idx == 5'd25 || idx == 5'd29) n = 3'd7;
    else n = 3'd4;
    return n;
  endfunction

  // sequence bytes, first byte in the top byte, zero padded
  function automatic logic [55:0] rom_entry(input logic [4:0] idx);
    logic [55:0] e;
    logic [7:0]  d;
    d = {3'b000, idx};
    if (idx == 5'd0) e = {CH_ESC, "[0;0m", 8'h00};
    else if (idx <= 5'd7) e = {CH_ESC, "[0;3", 8'(d + 8'h30), "m"};
    else if (idx <= 5'd14) e = {CH_ESC, "[1;3", 8'(d + 8'h29), "m"};
    else if (idx <= 5'd21) e = {CH_ESC, "[4", 8'(d + 8'h22), "m", 16'h0000};
    else if (idx == 5'd22) e = {CH_AMP, 48'h0};
    else if (idx == 5'd23) e = {CH_BSL, 48'h0};
    else if (idx == 5'd24) e = {CH_ESC, "[40m", 16'h0000};
    else if (idx == 5'd25) e = {CH_ESC, "[0;30m"};
    else if (idx == 5'd26) e = {CH_ESC, "[5m", 24'h000000};
    else if (idx == 5'd27) e = {CH_ESC, "[7m", 24'h000000};
    else if (idx == 5'd28) e = {CH_ESC, "[4m", 24'h000000};
    else e = {CH_ESC, "[1;30m"};
    return e;
  endfunction

endpackage

[sv/icce_front.sv]
// front end: parses input bytes, tracks colour state and output count,
// and builds one step descriptor per byte; uses icce_pkg

module icce_front #(
  parameter int OUT_LIMIT = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              text_last,
  output logic              wr,
  output icce_pkg::desc_t   wr_data
);
  import icce_pkg::*;

  localparam int CNT_W = $clog2(OUT_LIMIT + 8);
  localparam logic [CNT_W-1:0] LIMIT_V = CNT_W'(OUT_LIMIT);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_AMP   = 3'd1;
  localparam logic [2:0] PH_BSL   = 3'd2;
  localparam logic [2:0] PH_BSLC  = 3'd3;
  localparam logic [2:0] PH_BSLCD = 3'd4;

  localparam logic [2:0] CK_NONE   = 3'd0;
  localparam logic [2:0] CK_COL    = 3'd1;
  localparam logic [2:0] CK_SETDEF = 3'd2;
  localparam logic [2:0] CK_CLRDEF = 3'd3;
  localparam logic [2:0] CK_CHECK  = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] colour;
  } code_t;

  // letter after '&'
  function automatic code_t code_of(input logic [7:0] ch);
    code_t c;
    c.kind   = CK_COL;
    c.colour = 5'd0;
    case (ch)
      "k": c.colour = 5'd25;
      "r": c.colour = 5'd1;
      "g": c.colour = 5'd2;
      "y": c.colour = 5'd3;
      "b": c.colour = 5'd4;
      "m": c.colour = 5'd5;
      "c": c.colour = 5'd6;
      "w": c.colour = 5'd7;
      "K": c.colour = 5'd29;
      "R": c.colour = 5'd8;
      "G": c.colour = 5'd9;
      "Y": c.colour = 5'd10;
      "B": c.colour = 5'd11;
      "M": c.colour = 5'd12;
      "C": c.colour = 5'd13;
      "W": c.colour = 5'd14;
      "0": c.colour = 5'd24;
      "1": c.colour = 5'd15;
      "2": c.colour = 5'd16;
      "3": c.colour = 5'd17;
      "4": c.colour = 5'd18;
      "5": c.colour = 5'd19;
      "6": c.colour = 5'd20;
      "7": c.colour = 5'd21;
      "\\": c.colour = 5'd23;
      "n": c.colour = 5'd0;
      "f": c.colour = 5'd26;
      "v": c.colour = 5'd27;
      "u": c.colour = 5'd28;
      "q": c.kind = CK_SETDEF;
      "Q": c.kind = CK_CLRDEF;
      "e": c.kind = CK_CHECK;
      default: c.kind = CK_NONE;
    endcase
    return c;
  endfunction

  // bytes held by a partial code
  function automatic logic [2:0] flush_len(input logic [2:0] ph);
    logic [2:0] n;
    case (ph)
      PH_AMP:   n = 3'd1;
      PH_BSL:   n = 3'd1;
      PH_BSLC:  n = 3'd2;
      PH_BSLCD: n = 3'd3;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  logic             colour_enable;
  logic [2:0]       phase;
  logic [3:0]       held;
  logic             raw;
  logic [4:0]       cur_col;
  logic [4:0]       def_col;
  logic [CNT_W-1:0] cnt;
  logic             ovf;

  logic [2:0]       phase_next;
  logic [3:0]       held_next;
  logic             raw_next;
  logic [4:0]       cur_next;
  logic [4:0]       def_next;
  logic [CNT_W-1:0] cnt_next;
  logic             ovf_next;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_enable <= 1'b1;
    end else if (cfg_valid) begin
      colour_enable <= cfg_data;
    end
  end

  // per byte decode
  always_comb begin
    logic             digit;
    logic [6:0]       two_dig;
    code_t            code;
    logic             toggle;
    logic             fail;
    logic             idle_path;
    logic             do_expand;
    logic             do_bang;
    logic [2:0]       phase_h;
    logic [2:0]       pre_full;
    logic [2:0]       n_pre;
    logic [2:0]       n_post;
    logic [2:0]       post_full;
    logic [2:0]       s;
    logic [CNT_W-1:0] d;
    logic [4:0]       rom_idx;
    logic [2:0]       rom_n;
    logic [1:0]       mid_kind;
    logic [2:0]       mid_len;
    logic [7:0]       mid_byte;
    logic [3:0]       pb;
    logic             ovf_hit;
    logic             ovf_post;
    logic             ovf_total;
    logic             marker;
    logic [2:0]       b2;
    logic [2:0]       b3;

    digit   = (in_byte >= CH_ZERO) && (in_byte <= 8'h39);
    two_dig = 7'(held) * 7'd10 + 7'(in_byte[3:0]);
    code    = code_of(in_byte);
    toggle  = (!raw && in_byte == "S") || (raw && in_byte == "s");

    fail      = 1'b0;
    idle_path = 1'b0;
    do_expand = 1'b0;
    do_bang   = 1'b0;
    phase_h   = phase;
    held_next = held;
    raw_next  = raw;
    cur_next  = cur_col;
    def_next  = def_col;

    // code parser
    case (phase)
      PH_AMP: begin
        if (toggle) begin
          raw_next = !raw;
          phase_h  = PH_IDLE;
        end else if (!raw && code.kind != CK_NONE) begin
          phase_h = PH_IDLE;
          case (code.kind)
            CK_CHECK:  do_bang = (cur_col != 5'd0) && (cur_col != def_col);
            CK_SETDEF: def_next = cur_col;
            CK_CLRDEF: def_next = 5'd0;
            default: begin
              cur_next  = code.colour;
              do_expand = 1'b1;
            end
          endcase
        end else begin
          fail = 1'b1;
        end
      end
      PH_BSL: begin
        if (in_byte == CH_C) phase_h = PH_BSLC;
        else fail = 1'b1;
      end
      PH_BSLC: begin
        if (digit) begin
          held_next = in_byte[3:0];
          phase_h   = PH_BSLCD;
        end else begin
          fail = 1'b1;
        end
      end
      PH_BSLCD: begin
        if (digit) begin
          phase_h   = PH_IDLE;
          cur_next  = (two_dig >= 7'd30) ? 5'd0 : two_dig[4:0];
          do_expand = 1'b1;
        end else begin
          fail = 1'b1;
        end
      end
      default: idle_path = 1'b1;
    endcase
    idle_path = idle_path | fail;
    pre_full  = fail ? flush_len(phase) : 3'd0;

    // tokens left before the output limit trips
    d = LIMIT_V - cnt;
    if (cnt > LIMIT_V) s = 3'd0;
    else if (d >= CNT_W'(6)) s = 3'd7;
    else s = d[2:0] + 3'd1;

    // middle part
    rom_idx  = (cur_next == 5'd0 && def_next != 5'd0) ? def_next : cur_next;
    rom_n    = rom_len(rom_idx);
    mid_kind = MID_NONE;
    mid_len  = 3'd0;
    mid_byte = in_byte;
    ovf_hit  = 1'b0;
    n_pre    = (pre_full > s) ? s : pre_full;
    if (do_expand && (colour_enable || rom_n == 3'd1)) begin
      mid_kind = MID_ROM;
      mid_len  = rom_n;
    end
    if (do_bang) begin
      mid_kind = MID_BANG;
      mid_len  = 3'd3;
    end
    if (idle_path) begin
      phase_h = PH_IDLE;
      if (pre_full >= s) begin
        ovf_hit = 1'b1;
      end else if (in_byte == CH_AMP) begin
        phase_h = PH_AMP;
      end else if (!raw && in_byte == CH_BSL) begin
        phase_h = PH_BSL;
      end else begin
        mid_kind = MID_LIT;
        mid_len  = 3'd1;
        mid_byte = (!raw && in_byte == CH_US) ? CH_SP : in_byte;
      end
    end

    // end of text flush, only the flushed literals are checked against the limit
    post_full = (text_last && !ovf_hit) ? flush_len(phase_h) : 3'd0;
    pb        = {1'b0, n_pre} + {1'b0, mid_len};
    ovf_post  = 1'b0;
    n_post    = post_full;
    if (post_full != 3'd0 && pb + {1'b0, post_full} > {1'b0, s}) begin
      ovf_post = 1'b1;
      n_post   = ({1'b0, s} > pb) ? (s - pb[2:0]) : 3'd0;
    end
    ovf_total = ovf_hit | ovf_post;

    // already overflowed: drop everything but the end marker
    if (ovf) begin
      n_pre     = 3'd0;
      mid_kind  = MID_NONE;
      mid_len   = 3'd0;
      n_post    = 3'd0;
      ovf_total = 1'b0;
    end

    b2     = n_pre + mid_len;
    b3     = b2 + n_post;
    marker = ovf_total || (text_last && b3 == 3'd0);

    wr_data.pre_amp   = (phase == PH_AMP);
    wr_data.post_amp  = (phase_h == PH_AMP);
    wr_data.digit     = held_next;
    wr_data.mid_kind  = mid_kind;
    wr_data.mid_byte  = mid_byte;
    wr_data.rom_idx   = rom_idx;
    wr_data.b1        = n_pre;
    wr_data.b2        = b2;
    wr_data.b3        = b3;
    wr_data.total     = b3 + {2'b00, marker};
    wr_data.marker_ov = ovf_total | ovf;
    wr_data.text_end  = text_last;
    wr = accept && (b3 != 3'd0 || marker);

    // next state
    if (text_last) begin
      phase_next = PH_IDLE;
      held_next  = 4'd0;
      raw_next   = 1'b0;
      cur_next   = 5'd0;
      def_next   = 5'd0;
      cnt_next   = '0;
      ovf_next   = 1'b0;
    end else if (ovf) begin
      phase_next = phase;
      held_next  = held;
      raw_next   = raw;
      cur_next   = cur_col;
      def_next   = def_col;
      cnt_next   = cnt;
      ovf_next   = 1'b1;
    end else begin
      phase_next = phase_h;
      cnt_next   = cnt + CNT_W'(b3);
      ovf_next   = ovf_total;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      held    <= 4'd0;
      raw     <= 1'b0;
      cur_col <= 5'd0;
      def_col <= 5'd0;
      cnt     <= '0;
      ovf     <= 1'b0;
    end else if (accept) begin
      phase   <= phase_next;
      held    <= held_next;
      raw     <= raw_next;
      cur_col <= cur_next;
      def_col <= def_next;
      cnt     <= cnt_next;
      ovf     <= ovf_next;
    end
  end

endmodule

[sv/icce_queue.sv]
// short descriptor queue between the front end and the back end
// uses desc_t and the depth constants of icce_pkg

module icce_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  icce_pkg::desc_t wr_data,
  output logic            full,
  input  logic            rd,
  output icce_pkg::desc_t rd_data,
  output logic            empty
);
  import icce_pkg::*;

  desc_t          slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/icce_back.sv]
// back end: walks one step descriptor a result at a time into the output register
// uses desc_t, the mid kinds and the sequence rom of icce_pkg

module icce_back (
  input  logic            clk,
  input  logic            rst,
  input  icce_pkg::desc_t head,
  input  logic            empty,
  output logic            rd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            run_last,
  output logic            text_end,
  output logic            overflow
);
  import icce_pkg::*;

  // literal k of a held partial code
  function automatic logic [7:0] flush_byte(input logic amp, input logic [1:0] k,
                                            input logic [3:0] dig);
    logic [7:0] b;
    if (amp) b = CH_AMP;
    else if (k == 2'd0) b = CH_BSL;
    else if (k == 2'd1) b = CH_C;
    else b = {4'h3, dig};
    return b;
  endfunction

  function automatic logic [7:0] rom_byte(input logic [4:0] idx, input logic [2:0] k);
    logic [55:0] sh;
    sh = rom_entry(idx) << {k, 3'b000};
    return sh[55:48];
  endfunction

  logic [2:0] pos;
  logic       advance;
  logic       last;
  logic [7:0] nb;
  logic       nv;
  logic       nov;

  // result at the current position
  always_comb begin
    logic [2:0] k1;
    logic [2:0] k2;
    k1   = pos - head.b1;
    k2   = pos - head.b2;
    last = (pos == head.total - 3'd1);
    nv   = 1'b1;
    nov  = 1'b0;
    if (pos < head.b1) begin
      nb = flush_byte(head.pre_amp, pos[1:0], head.digit);
    end else if (pos < head.b2) begin
      case (head.mid_kind)
        MID_ROM:  nb = rom_byte(head.rom_idx, k1);
        MID_BANG: nb = CH_BANG;
        default:  nb = head.mid_byte;
      endcase
    end else if (pos < head.b3) begin
      nb = flush_byte(head.post_amp, k2[1:0], head.digit);
    end else begin
      nb  = 8'h00;
      nv  = 1'b0;
      nov = head.marker_ov;
    end
  end

  assign advance = (!out_valid || out_ready) && !empty;
  assign rd      = advance && last;

  // position within the current descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 3'd0;
    end else if (advance) begin
      pos <= last ? 3'd0 : pos + 3'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte   <= nb;
      byte_valid <= nv;
      run_last   <= last;
      text_end   <= last && head.text_end;
      overflow   <= nov;
    end
  end

endmodule

[sv/inline_colour_code_expander.sv]
// top level of the inline colour code expander: front end, descriptor queue, back end
// depends on icce_pkg, icce_front, icce_queue and icce_back
//
//   channel   handshake              payload
//   cfg       cfg_valid / cfg_ready  cfg_data (colour_enable)
//   in        in_valid / in_ready    in_byte, text_last
//   out       out_valid / out_ready  out_byte, byte_valid, run_last, text_end, overflow
//
// the front end takes one byte per cycle while the queue has room; a byte that
// gives n results holds the back end until all n are out (one result per cycle
// when out_ready allows, at most seven), and the four-entry queue absorbs bursts
// of expansions. bytes that give no result never reach the queue. sync reset
// returns all parse state to idle and colour_enable to 1. cfg_ready is always high.

module inline_colour_code_expander #(
  parameter int OUT_LIMIT = 16384
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       text_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       text_end,
  output logic       overflow
);
  import icce_pkg::*;

  logic  q_full;
  logic  q_empty;
  logic  q_wr;
  logic  q_rd;
  desc_t q_in;
  desc_t q_head;
  logic  accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // parse and classify
  icce_front #(
    .OUT_LIMIT(OUT_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .text_last (text_last),
    .wr        (q_wr),
    .wr_data   (q_in)
  );

  // step descriptors
  icce_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_in),
    .full    (q_full),
    .rd      (q_rd),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // expand into output words
  icce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .rd         (q_rd),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .text_end   (text_end),
    .overflow   (overflow)
  );

endmodule

[bench/inline_colour_code_expander_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for inline_colour_code_expander: random text with inline colour codes
// depends only on the rtl top level; the expected output words come from a predictor kept here

module inline_colour_code_expander_tb;

  localparam int LIMIT       = 64;    // small output limit so that overflow is reachable
  localparam int MAX_WORDS   = 7;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 12;

  // outcome of the letter after '&'
  localparam int CODE_NONE          = -1;
  localparam int CODE_SET_DEFAULT   = -2;
  localparam int CODE_CLEAR_DEFAULT = -3;
  localparam int CODE_CHECK_OPEN    = -4;

  typedef enum logic [2:0] {PH_IDLE, PH_AMP, PH_BSL, PH_BSLC, PH_BSLCD} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       text_end;
    logic       overflow;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       text_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       text_end;
  logic       overflow;

  inline_colour_code_expander #(.OUT_LIMIT(LIMIT)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .text_last(text_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .byte_valid(byte_valid), .run_last(run_last), .text_end(text_end), .overflow(overflow)
  );

  initial forever #6 clk = ~clk;

  text_item_t pending_bytes[$];
  out_word_t  expected_words[$];
  out_word_t  step_words[$];
  int         bytes_queued = 0;
  int         mismatches = 0;
  int         hold_asks = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         quiet_cycles = 0;
  bit         no_gaps = 1'b0;

  // predictor state
  bit           colour_en = 1'b1;
  parse_phase_t phase = PH_IDLE;
  logic [3:0]   held_digit = '0;
  bit           raw_mode = 1'b0;
  logic [4:0]   cur_colour = '0;
  logic [4:0]   dflt_colour = '0;
  logic [14:0]  out_count = '0;
  bit           overflowed = 1'b0;

  // escape sequence for a colour index
  function automatic string colour_seq(input logic [4:0] idx);
    if (idx == 0) return $sformatf("%c[0;0m", 8'h1b);
    if (idx <= 7) return $sformatf("%c[0;3%0dm", 8'h1b, idx);
    if (idx <= 14) return $sformatf("%c[1;3%0dm", 8'h1b, idx - 7);
    if (idx <= 21) return $sformatf("%c[4%0dm", 8'h1b, idx - 14);
    case (idx)
      22: return "&";
      23: return "\\";
      24: return $sformatf("%c[40m", 8'h1b);
      25: return $sformatf("%c[0;30m", 8'h1b);
      26: return $sformatf("%c[5m", 8'h1b);
      27: return $sformatf("%c[7m", 8'h1b);
      28: return $sformatf("%c[4m", 8'h1b);
      default: return $sformatf("%c[1;30m", 8'h1b);
    endcase
  endfunction

  function automatic int code_for_letter(input logic [7:0] b);
    case (b)
      "k": return 25;  "r": return 1;   "g": return 2;   "y": return 3;
      "b": return 4;   "m": return 5;   "c": return 6;   "w": return 7;
      "K": return 29;  "R": return 8;   "G": return 9;   "Y": return 10;
      "B": return 11;  "M": return 12;  "C": return 13;  "W": return 14;
      "0": return 24;  "1": return 15;  "2": return 16;  "3": return 17;
      "4": return 18;  "5": return 19;  "6": return 20;  "7": return 21;
      "\\": return 23; "n": return 0;   "f": return 26;  "v": return 27;
      "u": return 28;
      "q": return CODE_SET_DEFAULT;
      "Q": return CODE_CLEAR_DEFAULT;
      "e": return CODE_CHECK_OPEN;
      default: return CODE_NONE;
    endcase
  endfunction

  function automatic void emit_word(input logic [7:0] data, input bit valid);
    out_word_t w;
    if (step_words.size() >= MAX_WORDS) return;
    w.data = valid ? data : 8'h00;
    w.valid = valid;
    w.run_last = 1'b0;
    w.text_end = 1'b0;
    w.overflow = overflowed;
    step_words.push_back(w);
    if (valid) out_count++;
  endfunction

  // limit check before each token; trips once and drops the rest of the text
  function automatic bit literal_allowed();
    if (overflowed) return 1'b0;
    if (out_count > LIMIT) begin
      overflowed = 1'b1;
      emit_word(8'h00, 1'b0);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void emit_literal(input logic [7:0] b);
    if (literal_allowed()) emit_word(b, 1'b1);
  endfunction

  function automatic void expand_colour();
    logic [4:0] idx;
    string      s;
    if (cur_colour >= 30) cur_colour = 0;
    idx = (cur_colour == 0 && dflt_colour != 0) ? dflt_colour : cur_colour;
    if (idx >= 30) idx = 0;
    s = colour_seq(idx);
    // with colour off only the one-byte entries come out
    if (colour_en || s.len() == 1)
      for (int k = 0; k < s.len(); k++) emit_word(s[k], 1'b1);
  endfunction

  function automatic void idle_byte(input logic [7:0] b);
    if (!literal_allowed()) return;
    if (b == "&") phase = PH_AMP;
    else if (!raw_mode && b == "\\") phase = PH_BSL;
    else emit_word((!raw_mode && b == "_") ? 8'h20 : b, 1'b1);
  endfunction

  // partial code that did not match goes out as plain bytes
  function automatic void flush_held_code();
    parse_phase_t ph;
    ph = phase;
    phase = PH_IDLE;
    if (ph == PH_AMP) begin
      emit_literal("&");
    end else if (ph == PH_BSL || ph == PH_BSLC || ph == PH_BSLCD) begin
      emit_literal("\\");
      if (ph != PH_BSL) emit_literal("c");
      if (ph == PH_BSLCD) emit_literal(8'h30 + 8'(held_digit % 10));
    end
  endfunction

  function automatic void handle_text_byte(input logic [7:0] b);
    bit is_digit;
    bit no_match;
    int code;
    int v;
    is_digit = (b >= "0" && b <= "9");
    no_match = 1'b0;
    case (phase)
      PH_AMP: begin
        if ((!raw_mode && b == "S") || (raw_mode && b == "s")) begin
          raw_mode = !raw_mode;
          phase = PH_IDLE;
        end else begin
          code = raw_mode ? CODE_NONE : code_for_letter(b);
          if (code == CODE_NONE) begin
            no_match = 1'b1;
          end else begin
            phase = PH_IDLE;
            if (code == CODE_CHECK_OPEN) begin
              if (cur_colour != 0 && cur_colour != dflt_colour) begin
                emit_word("!", 1'b1);
                emit_word("!", 1'b1);
                emit_word("!", 1'b1);
              end
            end else if (code == CODE_SET_DEFAULT) begin
              dflt_colour = cur_colour;
            end else if (code == CODE_CLEAR_DEFAULT) begin
              dflt_colour = 0;
            end else begin
              cur_colour = 5'(code);
              expand_colour();
            end
          end
        end
      end
      PH_BSL: begin
        if (b == "c") phase = PH_BSLC;
        else no_match = 1'b1;
      end
      PH_BSLC: begin
        if (is_digit) begin
          held_digit = 4'(b - 8'h30);
          phase = PH_BSLCD;
        end else no_match = 1'b1;
      end
      PH_BSLCD: begin
        if (is_digit) begin
          v = (held_digit % 10) * 10 + (b - 8'h30);
          phase = PH_IDLE;
          cur_colour = (v >= 30) ? 5'd0 : 5'(v);
          expand_colour();
        end else no_match = 1'b1;
      end
      default: begin
        phase = PH_IDLE;
        idle_byte(b);
      end
    endcase
    if (no_match) begin
      flush_held_code();
      idle_byte(b);
    end
  endfunction

  function automatic void clear_text_state();
    phase = PH_IDLE;
    held_digit = '0;
    raw_mode = 1'b0;
    cur_colour = '0;
    dflt_colour = '0;
    out_count = '0;
    overflowed = 1'b0;
  endfunction

  // words caused by one accepted byte, appended to the expected words
  function automatic void predict_words(input logic [7:0] b, input bit last);
    out_word_t w;
    step_words.delete();
    if (!overflowed) handle_text_byte(b);
    if (last) begin
      if (!overflowed) flush_held_code();
      if (step_words.size() == 0) emit_word(8'h00, 1'b0);
      w = step_words[step_words.size() - 1];
      w.text_end = 1'b1;
      step_words[step_words.size() - 1] = w;
      clear_text_state();
    end
    if (step_words.size() > 0) begin
      w = step_words[step_words.size() - 1];
      w.run_last = 1'b1;
      step_words[step_words.size() - 1] = w;
    end
    foreach (step_words[k]) expected_words.push_back(step_words[k]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    text_item_t item;
    if (!rst) begin
      if (in_valid && in_ready) predict_words(in_byte, text_last);
      if (!(in_valid && !in_ready)) begin
        if (pending_bytes.size() > 0 && (no_gaps || $urandom_range(99) >= 28)) begin
          item = pending_bytes.pop_front();
          in_valid <= 1'b1;
          in_byte <= item.data;
          text_last <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and receiver stalls
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = {out_byte, byte_valid, run_last, text_end, overflow};
        if (expected_words.size() == 0) begin
          $error("word with nothing expected: out_byte %02h byte_valid %0b", out_byte,
                 byte_valid);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("out_byte", want.data, got.data);
          check_field("byte_valid", want.valid, got.valid);
          check_field("run_last", want.run_last, got.run_last);
          check_field("text_end", want.text_end, got.text_end);
          check_field("overflow", want.overflow, got.overflow);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || $urandom_range(99) >= 28;
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_item(input logic [7:0] data, input bit last);
    text_item_t item;
    item.data = data;
    item.last = last;
    pending_bytes.push_back(item);
    bytes_queued++;
  endtask

  task automatic queue_text(input string s);
    for (int k = 0; k < s.len(); k++) queue_item(s[k], k == s.len() - 1);
  endtask

  task automatic queue_directed();
    queue_text("&R&q&e");           // default equals current: no warning, bare end word
    queue_text("\\c29&e");          // two-digit colour then open colour warning
    queue_text("\\c30");            // value of thirty or more falls back to normal
    queue_text("&S\\_&s");          // raw mode copies backslash and underscore
    queue_text("&z_\\c5");          // failed code, underscore, code left open at end
    queue_item(8'h00, 1'b0);
    queue_item(8'hff, 1'b1);
  endtask

  // one text from code tokens, broken codes, raw sections and plain bytes
  task automatic queue_random_text(input bit long_text);
    string      letters;
    logic [7:0] t[$];
    int         ntok;
    int         kind;
    letters = "krgybmcwKRGYBMCW01234567\\nfvuqQeSs";
    ntok = long_text ? 24 : $urandom_range(1, 8);
    for (int i = 0; i < ntok; i++) begin
      kind = long_text ? 0 : $urandom_range(9);
      case (kind)
        0, 1, 2: begin
          t.push_back("&");
          t.push_back(letters[$urandom_range(letters.len() - 1)]);
        end
        3: begin
          t.push_back("\\");
          t.push_back("c");
          t.push_back(8'h30 + 8'($urandom_range(9)));
          t.push_back(8'h30 + 8'($urandom_range(9)));
        end
        4: begin
          case ($urandom_range(3))
            0: t.push_back("&");
            1: t.push_back("\\");
            2: begin t.push_back("\\"); t.push_back("c"); end
            default: begin
              t.push_back("\\");
              t.push_back("c");
              t.push_back(8'h30 + 8'($urandom_range(9)));
            end
          endcase
          t.push_back(8'($urandom_range(255)));
        end
        5, 6: t.push_back(8'($urandom_range(255)));
        7: t.push_back("_");
        8: begin
          t.push_back("&");
          t.push_back("S");
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
              0: t.push_back("\\");
              1: t.push_back("&");
              2: t.push_back("_");
              default: t.push_back(8'($urandom_range(255)));
            endcase
          end
          t.push_back("&");
          t.push_back("s");
        end
        default: begin
          t.push_back("&");
          t.push_back($urandom_range(1) ? "e" : "q");
        end
      endcase
    end
    foreach (t[k]) queue_item(t[k], k == t.size() - 1);
  endtask

  task automatic queue_random(input int n);
    int stop_at;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) queue_random_text($urandom_range(9) == 0);
  endtask

  // sender done, every word back, then a settle wait for bytes that give no word
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_colour_enable(input bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    colour_en = v;
    cfg_valid <= 1'b0;
  endtask

  // phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    wait_drained();

    write_colour_enable(1'b0);
    queue_directed();
    queue_random(50);
    wait_drained();

    // receiver holds off long enough for the block to back up
    write_colour_enable(1'b1);
    hold_asks++;
    queue_random(100);
    wait_drained();

    write_colour_enable(1'b0);
    no_gaps = 1'b1;
    queue_random(60);
    wait_drained();
    no_gaps = 1'b0;

    write_colour_enable(1'b1);
    queue_random(50);
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
